@@ hdl/gds_pkg.sv @@
// Shared widths, codes and record types for the graph diameter double sweep core.
`default_nettype none
package gds_pkg;

    localparam int NODE_W        = 10;
    localparam int LEN_W         = 15;
    localparam int DIST_W        = 27;
    localparam int CNT_W         = 11;
    localparam int PEDGE_W       = 13;
    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_MAX_EDGES = 4096;

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_COMPUTE = 2'd1,
        KIND_READ    = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_INDEX = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic [NODE_W-1:0] end_a;
        logic [NODE_W-1:0] end_b;
        logic [LEN_W-1:0]  len;
    } edge_t;

endpackage
`default_nettype wire

@@ hdl/gds_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ hdl/graph_diameter_double_sweep_core.sv @@
// Approximate graph diameter core: edge table, two shortest-path sweeps, path readback.
// Edge loads, clears and computes on an empty graph go straight to the finish state;
// path reads pass through a path RAM read state first. A compute item runs a sequencer
// over one node RAM read port and one edge RAM read port: a start scan over the loaded
// edges, then per sweep a clearing of the active nodes, a minimum search for every
// settled node plus a last one that finds none, after each settled node an edge scan
// that also reads the far node of every usable incident edge, and a farthest search;
// finally a walk that counts the path and a second walk that stores it, and the finish
// state hands the result out. The block takes no item while one is at work; a finished
// result waits while the output register holds a stalled item.
`default_nettype none
module graph_diameter_double_sweep_core #(
    parameter int MAX_NODES = gds_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = gds_pkg::DEF_MAX_EDGES
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [gds_pkg::CNT_W-1:0]     cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    kind,
    input  wire logic [gds_pkg::NODE_W-1:0]    end_a,
    input  wire logic [gds_pkg::NODE_W-1:0]    end_b,
    input  wire logic signed [15:0]            edge_length,
    input  wire logic [gds_pkg::NODE_W-1:0]    path_index,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [1:0]                         status,
    output logic [gds_pkg::DIST_W-1:0]         diameter_length,
    output logic [gds_pkg::NODE_W-1:0]         end_node_first,
    output logic [gds_pkg::NODE_W-1:0]         end_node_second,
    output logic [gds_pkg::CNT_W-1:0]          path_count,
    output logic [gds_pkg::NODE_W-1:0]         path_node,
    output logic [gds_pkg::PEDGE_W-1:0]        path_edge
);

    localparam int NODE_LIM = (MAX_NODES < 1024) ? MAX_NODES : 1024;
    localparam int NAW      = $clog2(NODE_LIM);
    localparam int ECW      = $clog2(MAX_EDGES + 1);
    localparam int EAW      = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int NW       = gds_pkg::NODE_W;
    localparam int DW       = gds_pkg::DIST_W;
    localparam int CW       = gds_pkg::CNT_W;

    typedef struct packed {
        logic          reached;
        logic          settled;
        logic [DW-1:0] dist_val;
        logic [NW-1:0] pnode;
        logic [ECW-1:0] pedge;
    } node_t;

    typedef struct packed {
        logic [NW-1:0]  node;
        logic [ECW-1:0] pedge;
    } path_t;

    typedef enum logic [17:0] {
        S_IDLE    = 18'h00001,
        S_PRD     = 18'h00002,
        S_ST_RD   = 18'h00004,
        S_ST_CHK  = 18'h00008,
        S_CLR     = 18'h00010,
        S_SEL_RD  = 18'h00020,
        S_SEL_CHK = 18'h00040,
        S_REL_RD  = 18'h00080,
        S_REL_CHK = 18'h00100,
        S_V_RD    = 18'h00200,
        S_V_CHK   = 18'h00400,
        S_FAR_RD  = 18'h00800,
        S_FAR_CHK = 18'h01000,
        S_W1_RD   = 18'h02000,
        S_W1_CHK  = 18'h04000,
        S_W2_RD   = 18'h08000,
        S_W2_CHK  = 18'h10000,
        S_FIN     = 18'h20000
    } state_t;

    state_t         state_reg;
    logic [CW-1:0]  node_count_reg;
    logic [ECW-1:0] edge_count_reg;
    logic [CW-1:0]  n_reg;
    logic [CW-1:0]  nl_reg;
    logic [CW-1:0]  i_reg;
    logic [ECW-1:0] e_reg;
    logic           found_reg;
    logic           have_reg;
    logic           sweep_reg;
    logic [NW-1:0]  u_reg;
    node_t          best_reg;
    logic [NW-1:0]  v_reg;
    logic [DW-1:0]  nd_reg;
    logic [NW-1:0]  src_reg;
    logic [NW-1:0]  start_reg;
    logic [NW-1:0]  far_reg;
    logic [DW-1:0]  far_d_reg;
    logic [NW-1:0]  a_reg;
    logic [NW-1:0]  b_reg;
    logic [DW-1:0]  diam_len_reg;
    logic [CW-1:0]  path_len_reg;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  k_reg;
    logic [NW-1:0]  cur_reg;
    logic [NW-1:0]  idx_reg;

    logic [1:0]     res_status_reg;
    logic [DW-1:0]  res_dl_reg;
    logic [NW-1:0]  res_fa_reg;
    logic [NW-1:0]  res_fb_reg;
    logic [CW-1:0]  res_pc_reg;
    logic [NW-1:0]  res_pn_reg;
    logic [gds_pkg::PEDGE_W-1:0] res_pe_reg;
    logic           out_valid_reg;

    logic           er_we;
    gds_pkg::edge_t er_wdata;
    gds_pkg::edge_t er_rdata;
    logic           nr_we;
    logic [NAW-1:0] nr_waddr;
    logic [NAW-1:0] nr_raddr;
    node_t          nr_wdata;
    node_t          nr_rdata;
    logic           pr_we;
    logic [NAW-1:0] pr_waddr;
    path_t          pr_wdata;
    path_t          pr_rdata;

    logic [CW-1:0]  n_cur;
    logic [CW-1:0]  nl_cur;
    logic           edge_ok;
    logic [NW-1:0]  edge_min;
    logic [CW-1:0]  pos;
    logic           relax;

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    assign n_cur  = (32'(node_count_reg) > MAX_NODES) ? CW'(MAX_NODES) : node_count_reg;
    assign nl_cur = (32'(n_cur) > NODE_LIM) ? CW'(NODE_LIM) : n_cur;

    assign edge_ok  = ({1'b0, er_rdata.end_a} < n_reg) && ({1'b0, er_rdata.end_b} < n_reg);
    assign edge_min = (er_rdata.end_a < er_rdata.end_b) ? er_rdata.end_a : er_rdata.end_b;
    assign pos      = cnt_reg - k_reg - CW'(1);
    assign relax    = !nr_rdata.reached || (nd_reg < nr_rdata.dist_val);

    assign er_we          = (state_reg == S_IDLE) && in_valid && (kind == gds_pkg::KIND_LOAD)
                            && (32'(edge_count_reg) < MAX_EDGES);
    assign er_wdata.end_a = end_a;
    assign er_wdata.end_b = end_b;
    assign er_wdata.len   = edge_length[15] ? '0 : edge_length[14:0];

    gds_ram #(.WIDTH($bits(gds_pkg::edge_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (er_we),
        .waddr (edge_count_reg[EAW-1:0]),
        .wdata (er_wdata),
        .raddr (e_reg[EAW-1:0]),
        .rdata (er_rdata)
    );

    gds_ram #(.WIDTH($bits(node_t)), .DEPTH(NODE_LIM)) u_node_ram (
        .clk   (clk),
        .we    (nr_we),
        .waddr (nr_waddr),
        .wdata (nr_wdata),
        .raddr (nr_raddr),
        .rdata (nr_rdata)
    );

    gds_ram #(.WIDTH($bits(path_t)), .DEPTH(NODE_LIM)) u_path_ram (
        .clk   (clk),
        .we    (pr_we),
        .waddr (pr_waddr),
        .wdata (pr_wdata),
        .raddr (path_index[NAW-1:0]),
        .rdata (pr_rdata)
    );

    always_comb
    begin
        nr_raddr       = i_reg[NAW-1:0];
        nr_we          = 1'b0;
        nr_waddr       = i_reg[NAW-1:0];
        nr_wdata       = '0;
        nr_wdata.pedge = ECW'(MAX_EDGES);
        pr_we          = 1'b0;
        pr_waddr       = pos[NAW-1:0];
        pr_wdata.node  = cur_reg;
        pr_wdata.pedge = (pos == '0) ? ECW'(MAX_EDGES) : nr_rdata.pedge;
        case (state_reg)
            S_CLR:
            begin
                nr_we = 1'b1;
                if (i_reg == nl_reg)
                begin
                    nr_waddr         = src_reg[NAW-1:0];
                    nr_wdata.reached = 1'b1;
                end
            end
            S_SEL_RD:
            begin
                if ((i_reg == nl_reg) && found_reg)
                begin
                    nr_we            = 1'b1;
                    nr_waddr         = u_reg[NAW-1:0];
                    nr_wdata         = best_reg;
                    nr_wdata.settled = 1'b1;
                end
            end
            S_V_RD:
            begin
                nr_raddr = v_reg[NAW-1:0];
            end
            S_V_CHK:
            begin
                nr_raddr          = v_reg[NAW-1:0];
                nr_we             = relax;
                nr_waddr          = v_reg[NAW-1:0];
                nr_wdata.reached  = 1'b1;
                nr_wdata.settled  = nr_rdata.settled;
                nr_wdata.dist_val = nd_reg;
                nr_wdata.pnode    = u_reg;
                nr_wdata.pedge    = e_reg;
            end
            S_W1_RD, S_W1_CHK, S_W2_RD:
            begin
                nr_raddr = cur_reg[NAW-1:0];
            end
            S_W2_CHK:
            begin
                nr_raddr = cur_reg[NAW-1:0];
                pr_we    = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= '0;
            edge_count_reg <= '0;
            n_reg          <= '0;
            nl_reg         <= '0;
            i_reg          <= '0;
            e_reg          <= '0;
            found_reg      <= 1'b0;
            have_reg       <= 1'b0;
            sweep_reg      <= 1'b0;
            u_reg          <= '0;
            best_reg       <= '0;
            v_reg          <= '0;
            nd_reg         <= '0;
            src_reg        <= '0;
            start_reg      <= '0;
            far_reg        <= '0;
            far_d_reg      <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            diam_len_reg   <= '0;
            path_len_reg   <= '0;
            cnt_reg        <= '0;
            k_reg          <= '0;
            cur_reg        <= '0;
            idx_reg        <= '0;
            res_status_reg <= '0;
            res_dl_reg     <= '0;
            res_fa_reg     <= '0;
            res_fb_reg     <= '0;
            res_pc_reg     <= '0;
            res_pn_reg     <= '0;
            res_pe_reg     <= '0;
            out_valid_reg  <= 1'b0;
            status          <= '0;
            diameter_length <= '0;
            end_node_first  <= '0;
            end_node_second <= '0;
            path_count      <= '0;
            path_node       <= '0;
            path_edge       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (out_valid_reg && !out_stall && (state_reg != S_FIN))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        idx_reg        <= path_index;
                        n_reg          <= n_cur;
                        nl_reg         <= nl_cur;
                        res_dl_reg     <= '0;
                        res_fa_reg     <= '0;
                        res_fb_reg     <= '0;
                        res_pc_reg     <= '0;
                        res_pn_reg     <= '0;
                        res_pe_reg     <= '0;
                        case (kind)
                            gds_pkg::KIND_LOAD:
                            begin
                                state_reg <= S_FIN;
                                if (er_we)
                                begin
                                    edge_count_reg <= edge_count_reg + ECW'(1);
                                    res_status_reg <= gds_pkg::STAT_OK;
                                end
                                else
                                begin
                                    res_status_reg <= gds_pkg::STAT_FULL;
                                end
                            end
                            gds_pkg::KIND_CLEAR:
                            begin
                                edge_count_reg <= '0;
                                res_status_reg <= gds_pkg::STAT_OK;
                                state_reg      <= S_FIN;
                            end
                            gds_pkg::KIND_READ:
                            begin
                                res_status_reg <= gds_pkg::STAT_OK;
                                state_reg      <= S_PRD;
                            end
                            default:
                            begin
                                if (n_cur == '0)
                                begin
                                    path_len_reg   <= '0;
                                    diam_len_reg   <= '0;
                                    a_reg          <= '0;
                                    b_reg          <= '0;
                                    res_status_reg <= gds_pkg::STAT_EMPTY;
                                    state_reg      <= S_FIN;
                                end
                                else
                                begin
                                    e_reg          <= '0;
                                    have_reg       <= 1'b0;
                                    start_reg      <= '0;
                                    res_status_reg <= gds_pkg::STAT_OK;
                                    state_reg      <= S_ST_RD;
                                end
                            end
                        endcase
                    end
                end
                S_PRD:
                begin
                    res_dl_reg <= diam_len_reg;
                    res_fa_reg <= a_reg;
                    res_fb_reg <= b_reg;
                    res_pc_reg <= path_len_reg;
                    if ({1'b0, idx_reg} < path_len_reg)
                    begin
                        res_pn_reg <= pr_rdata.node;
                        res_pe_reg <= gds_pkg::PEDGE_W'(pr_rdata.pedge);
                    end
                    else
                    begin
                        res_status_reg <= gds_pkg::STAT_INDEX;
                    end
                    state_reg <= S_FIN;
                end
                S_ST_RD:
                begin
                    if (e_reg == edge_count_reg)
                    begin
                        src_reg   <= start_reg;
                        sweep_reg <= 1'b0;
                        i_reg     <= '0;
                        state_reg <= S_CLR;
                    end
                    else
                    begin
                        state_reg <= S_ST_CHK;
                    end
                end
                S_ST_CHK:
                begin
                    if (edge_ok && (!have_reg || (edge_min < start_reg)))
                    begin
                        start_reg <= edge_min;
                        have_reg  <= 1'b1;
                    end
                    e_reg     <= e_reg + ECW'(1);
                    state_reg <= S_ST_RD;
                end
                S_CLR:
                begin
                    if (i_reg == nl_reg)
                    begin
                        i_reg     <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_SEL_RD;
                    end
                    else
                    begin
                        i_reg <= i_reg + CW'(1);
                    end
                end
                S_SEL_RD:
                begin
                    if (i_reg == nl_reg)
                    begin
                        i_reg     <= '0;
                        e_reg     <= '0;
                        found_reg <= 1'b0;
                        state_reg <= found_reg ? S_REL_RD : S_FAR_RD;
                    end
                    else
                    begin
                        state_reg <= S_SEL_CHK;
                    end
                end
                S_SEL_CHK:
                begin
                    if (nr_rdata.reached && !nr_rdata.settled
                        && (!found_reg || (nr_rdata.dist_val < best_reg.dist_val)))
                    begin
                        best_reg  <= nr_rdata;
                        u_reg     <= NW'(i_reg);
                        found_reg <= 1'b1;
                    end
                    i_reg     <= i_reg + CW'(1);
                    state_reg <= S_SEL_RD;
                end
                S_REL_RD:
                begin
                    if (e_reg == edge_count_reg)
                    begin
                        i_reg     <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_SEL_RD;
                    end
                    else
                    begin
                        state_reg <= S_REL_CHK;
                    end
                end
                S_REL_CHK:
                begin
                    if (edge_ok && ((er_rdata.end_a == u_reg) || (er_rdata.end_b == u_reg)))
                    begin
                        v_reg     <= (er_rdata.end_a == u_reg) ? er_rdata.end_b : er_rdata.end_a;
                        nd_reg    <= best_reg.dist_val + DW'(er_rdata.len);
                        state_reg <= S_V_RD;
                    end
                    else
                    begin
                        e_reg     <= e_reg + ECW'(1);
                        state_reg <= S_REL_RD;
                    end
                end
                S_V_RD:
                begin
                    state_reg <= S_V_CHK;
                end
                S_V_CHK:
                begin
                    e_reg     <= e_reg + ECW'(1);
                    state_reg <= S_REL_RD;
                end
                S_FAR_RD:
                begin
                    if (i_reg == nl_reg)
                    begin
                        i_reg <= '0;
                        if (!sweep_reg)
                        begin
                            src_reg   <= far_reg;
                            sweep_reg <= 1'b1;
                            state_reg <= S_CLR;
                        end
                        else
                        begin
                            a_reg        <= src_reg;
                            b_reg        <= far_reg;
                            diam_len_reg <= far_d_reg;
                            cur_reg      <= far_reg;
                            cnt_reg      <= '0;
                            state_reg    <= S_W1_RD;
                        end
                    end
                    else
                    begin
                        state_reg <= S_FAR_CHK;
                    end
                    if (i_reg == '0)
                    begin
                        far_reg   <= '0;
                        far_d_reg <= '0;
                    end
                end
                S_FAR_CHK:
                begin
                    if (nr_rdata.reached && (!found_reg || (nr_rdata.dist_val > far_d_reg)))
                    begin
                        far_reg   <= NW'(i_reg);
                        far_d_reg <= nr_rdata.dist_val;
                        found_reg <= 1'b1;
                    end
                    i_reg     <= i_reg + CW'(1);
                    state_reg <= S_FAR_RD;
                end
                S_W1_RD:
                begin
                    state_reg <= S_W1_CHK;
                end
                S_W1_CHK:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                    if ((cur_reg == a_reg) || ((cnt_reg + CW'(1)) >= n_reg))
                    begin
                        cur_reg   <= b_reg;
                        k_reg     <= '0;
                        state_reg <= S_W2_RD;
                    end
                    else
                    begin
                        cur_reg   <= nr_rdata.pnode;
                        state_reg <= S_W1_RD;
                    end
                end
                S_W2_RD:
                begin
                    state_reg <= S_W2_CHK;
                end
                S_W2_CHK:
                begin
                    k_reg   <= k_reg + CW'(1);
                    cur_reg <= nr_rdata.pnode;
                    if ((k_reg + CW'(1)) == cnt_reg)
                    begin
                        path_len_reg <= cnt_reg;
                        res_dl_reg   <= diam_len_reg;
                        res_fa_reg   <= a_reg;
                        res_fb_reg   <= b_reg;
                        res_pc_reg   <= cnt_reg;
                        res_pn_reg   <= cur_reg;
                        res_pe_reg   <= gds_pkg::PEDGE_W'(MAX_EDGES);
                        state_reg    <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_W2_RD;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        status          <= res_status_reg;
                        diameter_length <= res_dl_reg;
                        end_node_first  <= res_fa_reg;
                        end_node_second <= res_fb_reg;
                        path_count      <= res_pc_reg;
                        path_node       <= res_pn_reg;
                        path_edge       <= res_pe_reg;
                        out_valid_reg   <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_edge_count: assert property (@(posedge clk) disable iff (!rst_n)
        32'(edge_count_reg) <= MAX_EDGES)
        else $error("edge count beyond table");

    a_path_len: assert property (@(posedge clk) disable iff (!rst_n)
        32'(path_len_reg) <= NODE_LIM)
        else $error("path length beyond node store");

    a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) && !out_valid_reg |=> out_valid_reg && (state_reg == S_IDLE))
        else $error("finished item not delivered");

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking testbench for the graph diameter double sweep core.
`default_nettype none
module tb_top;

    localparam int NMAX     = gds_pkg::DEF_MAX_NODES;
    localparam int EMAX     = gds_pkg::DEF_MAX_EDGES;
    localparam int WD_LIMIT = 4000000;

    typedef struct {
        gds_pkg::kind_t             kind;
        logic [gds_pkg::NODE_W-1:0] a;
        logic [gds_pkg::NODE_W-1:0] b;
        logic [15:0]                len;
        logic [gds_pkg::NODE_W-1:0] idx;
    } op_t;

    typedef struct {
        logic [1:0]                  status;
        logic [gds_pkg::DIST_W-1:0]  dlen;
        logic [gds_pkg::NODE_W-1:0]  fa;
        logic [gds_pkg::NODE_W-1:0]  fb;
        logic [gds_pkg::CNT_W-1:0]   pcount;
        logic [gds_pkg::NODE_W-1:0]  pnode;
        logic [gds_pkg::PEDGE_W-1:0] pedge;
    } res_t;

    logic clk, rst_n;
    logic cfg_we;
    logic [gds_pkg::CNT_W-1:0] cfg_wdata;
    logic in_valid, in_stall;
    logic [1:0] kind;
    logic [gds_pkg::NODE_W-1:0] end_a, end_b, path_index;
    logic signed [15:0] edge_length;
    logic out_valid, out_stall;
    logic [1:0] status;
    logic [gds_pkg::DIST_W-1:0] diameter_length;
    logic [gds_pkg::NODE_W-1:0] end_node_first, end_node_second, path_node;
    logic [gds_pkg::CNT_W-1:0] path_count;
    logic [gds_pkg::PEDGE_W-1:0] path_edge;

    graph_diameter_double_sweep_core u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .end_a(end_a),
        .end_b(end_b), .edge_length(edge_length), .path_index(path_index),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .diameter_length(diameter_length), .end_node_first(end_node_first),
        .end_node_second(end_node_second), .path_count(path_count),
        .path_node(path_node), .path_edge(path_edge)
    );

    op_t  op_q[$];
    res_t result_q[$];
    op_t  cur_op;
    int   errors = 0;
    int   op_total = 0;
    int   in_gap = 0;
    int   out_gap = 0;
    int   idle_cycles = 0;
    bit   quiet = 0;
    bit   calm = 0;

    // graph and path state of the predictor
    int unsigned edge_a[EMAX], edge_b[EMAX], edge_w[EMAX];
    int unsigned edge_total = 0;
    int unsigned node_limit = 0;
    int unsigned node_dist[NMAX], par_node[NMAX], par_edge[NMAX];
    bit          seen[NMAX], done[NMAX];
    int unsigned route_node[NMAX], route_edge[NMAX];
    int unsigned route_len = 0, span = 0, span_a = 0, span_b = 0;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic void sweep_from(int unsigned src, int unsigned n);
        int unsigned u, v, nd;
        bit found;
        for (int i = 0; i < n; i++)
        begin
            seen[i] = 0;
            done[i] = 0;
            node_dist[i] = 0;
            par_node[i] = 0;
            par_edge[i] = EMAX;
        end
        seen[src] = 1;
        while (1)
        begin
            found = 0;
            u = 0;
            for (int i = 0; i < n; i++)
                if (seen[i] && !done[i] && (!found || node_dist[i] < node_dist[u]))
                begin
                    u = i;
                    found = 1;
                end
            if (!found)
                break;
            done[u] = 1;
            for (int e = 0; e < edge_total; e++)
            begin
                if (edge_a[e] >= n || edge_b[e] >= n)
                    continue;
                if (edge_a[e] == u)
                    v = edge_b[e];
                else if (edge_b[e] == u)
                    v = edge_a[e];
                else
                    continue;
                nd = node_dist[u] + edge_w[e];
                if (!seen[v] || nd < node_dist[v])
                begin
                    seen[v] = 1;
                    node_dist[v] = nd;
                    par_node[v] = u;
                    par_edge[v] = e;
                end
            end
        end
    endfunction

    function automatic int unsigned farthest_node(int unsigned n);
        int unsigned best;
        bit found;
        best = 0;
        found = 0;
        for (int i = 0; i < n; i++)
            if (seen[i] && (!found || node_dist[i] > node_dist[best]))
            begin
                best = i;
                found = 1;
            end
        return best;
    endfunction

    function automatic gds_pkg::status_t run_diameter();
        int unsigned n, start, m, cur, cnt, t;
        bit have;
        n = node_limit > NMAX ? NMAX : node_limit;
        if (n == 0)
        begin
            route_len = 0;
            span = 0;
            span_a = 0;
            span_b = 0;
            return gds_pkg::STAT_EMPTY;
        end
        start = 0;
        have = 0;
        for (int e = 0; e < edge_total; e++)
        begin
            if (edge_a[e] >= n || edge_b[e] >= n)
                continue;
            m = edge_a[e] < edge_b[e] ? edge_a[e] : edge_b[e];
            if (!have || m < start)
            begin
                start = m;
                have = 1;
            end
        end
        sweep_from(start, n);
        span_a = farthest_node(n);
        sweep_from(span_a, n);
        span_b = farthest_node(n);
        span = node_dist[span_b];
        cur = span_b;
        cnt = 0;
        while (cnt < n)
        begin
            route_node[cnt] = cur;
            cnt++;
            if (cur == span_a)
                break;
            cur = par_node[cur];
        end
        for (int i = 0; i < cnt / 2; i++)
        begin
            t = route_node[i];
            route_node[i] = route_node[cnt - 1 - i];
            route_node[cnt - 1 - i] = t;
        end
        for (int i = 0; i < cnt; i++)
            route_edge[i] = (i == 0) ? EMAX : par_edge[route_node[i]];
        route_len = cnt;
        return gds_pkg::STAT_OK;
    endfunction

    function automatic res_t predict_result(op_t op);
        res_t r;
        int unsigned idx;
        r = '{default: '0};
        r.status = gds_pkg::STAT_OK;
        idx = 32'(op.idx);
        case (op.kind)
            gds_pkg::KIND_LOAD:
            begin
                if (edge_total >= EMAX)
                    r.status = gds_pkg::STAT_FULL;
                else
                begin
                    edge_a[edge_total] = 32'(op.a);
                    edge_b[edge_total] = 32'(op.b);
                    edge_w[edge_total] = op.len[15] ? 0 : 32'(op.len);
                    edge_total++;
                end
            end
            gds_pkg::KIND_CLEAR:
                edge_total = 0;
            default:
            begin
                if (op.kind == gds_pkg::KIND_COMPUTE)
                begin
                    r.status = run_diameter();
                    idx = 0;
                end
                if (r.status == gds_pkg::STAT_OK)
                begin
                    r.dlen = gds_pkg::DIST_W'(span);
                    r.fa = gds_pkg::NODE_W'(span_a);
                    r.fb = gds_pkg::NODE_W'(span_b);
                    r.pcount = gds_pkg::CNT_W'(route_len);
                    if (idx < route_len)
                    begin
                        r.pnode = gds_pkg::NODE_W'(route_node[idx]);
                        r.pedge = gds_pkg::PEDGE_W'(route_edge[idx]);
                    end
                    else
                        r.status = gds_pkg::STAT_INDEX;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // item driver
    always @(posedge clk)
    begin
        logic nv;
        nv = in_valid;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                result_q.insert(result_q.size(), predict_result(cur_op));
                nv = 0;
            end
            if (!nv)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (op_q.size() > 0)
                begin
                    if (!quiet && !calm && $urandom_range(0, 6) == 0)
                        in_gap = $urandom_range(0, 2);
                    else
                    begin
                        cur_op = op_q.pop_front();
                        kind <= cur_op.kind;
                        end_a <= cur_op.a;
                        end_b <= cur_op.b;
                        edge_length <= cur_op.len;
                        path_index <= cur_op.idx;
                        nv = 1;
                    end
                end
            end
        end
        in_valid <= nv;
    end

    // result monitor
    always @(posedge clk)
    begin
        res_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_q.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                w = result_q.pop_front();
                if (status !== w.status) report_mismatch("status", status, w.status);
                if (diameter_length !== w.dlen)
                    report_mismatch("diameter_length", diameter_length, w.dlen);
                if (end_node_first !== w.fa)
                    report_mismatch("end_node_first", end_node_first, w.fa);
                if (end_node_second !== w.fb)
                    report_mismatch("end_node_second", end_node_second, w.fb);
                if (path_count !== w.pcount) report_mismatch("path_count", path_count, w.pcount);
                if (path_node !== w.pnode) report_mismatch("path_node", path_node, w.pnode);
                if (path_edge !== w.pedge) report_mismatch("path_edge", path_edge, w.pedge);
            end
        end
        if (!rst_n || quiet || calm)
            out_stall <= 0;
        else if (out_gap > 0)
        begin
            out_gap--;
            out_stall <= 1;
        end
        else if ($urandom_range(0, 6) == 0)
        begin
            out_gap = $urandom_range(0, 2);
            out_stall <= 1;
        end
        else
            out_stall <= 0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WD_LIMIT)
        begin
            $display("graph_diameter_double_sweep_core test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic add_op(gds_pkg::kind_t k, int unsigned a, int unsigned b, logic [15:0] len,
                          int unsigned idx);
        op_t op;
        op.kind = k;
        op.a = gds_pkg::NODE_W'(a);
        op.b = gds_pkg::NODE_W'(b);
        op.len = len;
        op.idx = gds_pkg::NODE_W'(idx);
        op_q.insert(op_q.size(), op);
        op_total++;
    endtask

    task automatic drain();
        while (op_q.size() != 0 || in_valid || result_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_nodes(int unsigned v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= gds_pkg::CNT_W'(v);
        @(posedge clk);
        cfg_we <= 0;
        node_limit = v;
        calm = ($urandom_range(0, 3) == 0);
    endtask

    function automatic logic [15:0] pick_len();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000 | 16'($urandom);
            2: return 16'h0000;
            3: return 16'($urandom);
            default: return 16'($urandom_range(0, 60));
        endcase
    endfunction

    function automatic int unsigned pick_node(int unsigned n);
        if (n == 0 || $urandom_range(0, 15) == 0)
            return $urandom_range(0, 1023);
        return $urandom_range(0, (n + 1 > 1023) ? 1023 : n + 1);
    endfunction

    task automatic random_graph(int unsigned n);
        int unsigned loads, reads, lim;
        if ($urandom_range(0, 1))
            add_op(gds_pkg::KIND_CLEAR, $urandom, $urandom, 16'($urandom), $urandom);
        loads = $urandom_range(0, 30);
        for (int i = 0; i < loads; i++)
            add_op(gds_pkg::KIND_LOAD, pick_node(n), pick_node(n), pick_len(), $urandom);
        add_op(gds_pkg::KIND_COMPUTE, $urandom, $urandom, 16'($urandom), $urandom);
        lim = (n > NMAX ? NMAX : n) + 2;
        reads = $urandom_range(1, 8);
        for (int i = 0; i < reads; i++)
            add_op(gds_pkg::KIND_READ, $urandom, $urandom, 16'($urandom),
                   $urandom_range(0, 5) == 0 ? $urandom_range(0, 1023)
                                             : $urandom_range(0, lim > 1023 ? 1023 : lim));
        if ($urandom_range(0, 4) == 0)
            add_op(gds_pkg::kind_t'($urandom_range(0, 3)), $urandom, $urandom, 16'($urandom),
                   $urandom);
    endtask

    initial
    begin
        int unsigned n;
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = '0;
        in_valid = 0;
        out_stall = 0;
        kind = '0;
        end_a = '0;
        end_b = '0;
        edge_length = '0;
        path_index = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        add_op(gds_pkg::KIND_READ, 0, 0, 0, 0);
        add_op(gds_pkg::KIND_COMPUTE, 0, 0, 0, 0);
        add_op(gds_pkg::KIND_LOAD, 1, 2, 16'd3, 0);
        add_op(gds_pkg::KIND_COMPUTE, 0, 0, 0, 0);

        set_nodes(8);
        add_op(gds_pkg::KIND_LOAD, 3, 1, 16'd5, 0);
        add_op(gds_pkg::KIND_LOAD, 1, 2, 16'hffff, 0);
        add_op(gds_pkg::KIND_LOAD, 2, 6, 16'h7fff, 0);
        add_op(gds_pkg::KIND_LOAD, 4, 1023, 16'd9, 0);
        add_op(gds_pkg::KIND_LOAD, 5, 6, 16'h8000, 0);
        add_op(gds_pkg::KIND_LOAD, 6, 3, 16'd1, 0);
        add_op(gds_pkg::KIND_LOAD, 5, 5, 16'd4, 0);
        add_op(gds_pkg::KIND_COMPUTE, 0, 0, 0, 0);
        for (int i = 0; i < 5; i++)
            add_op(gds_pkg::KIND_READ, 0, 0, 0, i);
        add_op(gds_pkg::KIND_READ, 0, 0, 0, 1023);
        add_op(gds_pkg::KIND_CLEAR, 0, 0, 0, 0);
        add_op(gds_pkg::KIND_READ, 0, 0, 0, 1);
        add_op(gds_pkg::KIND_COMPUTE, 0, 0, 0, 0);
        add_op(gds_pkg::KIND_READ, 0, 0, 0, 0);

        set_nodes(NMAX);
        add_op(gds_pkg::KIND_LOAD, 1023, 512, 16'd7, 0);
        add_op(gds_pkg::KIND_LOAD, 512, 0, 16'd2, 0);
        add_op(gds_pkg::KIND_COMPUTE, 0, 0, 0, 0);
        add_op(gds_pkg::KIND_READ, 0, 0, 0, 2);
        set_nodes(2047);
        add_op(gds_pkg::KIND_COMPUTE, 0, 0, 0, 0);
        add_op(gds_pkg::KIND_READ, 0, 0, 0, 1);

        // many parallel edges on a tiny graph
        set_nodes(4);
        add_op(gds_pkg::KIND_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < 200; i++)
            add_op(gds_pkg::KIND_LOAD, $urandom_range(0, 5), $urandom_range(0, 5),
                   pick_len(), 0);
        add_op(gds_pkg::KIND_COMPUTE, 0, 0, 0, 0);
        add_op(gds_pkg::KIND_READ, 0, 0, 0, $urandom_range(0, 4));
        add_op(gds_pkg::KIND_CLEAR, 0, 0, 0, 0);

        while (op_total < 1750)
        begin
            case ($urandom_range(0, 19))
                0: n = 0;
                1: n = 1;
                2: n = NMAX;
                3: n = $urandom_range(0, 2047);
                default: n = $urandom_range(2, 20);
            endcase
            set_nodes(n);
            if (op_total > 1500)
                quiet = 1;
            random_graph(n);
        end

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("graph_diameter_double_sweep_core test passed");
        else
            $display("graph_diameter_double_sweep_core test failed");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
hdl/gds_pkg.sv
hdl/gds_ram.sv
hdl/graph_diameter_double_sweep_core.sv
bench/tb_top.sv
